// File: sv/cau_pkg.sv
// Shared types, constants and the saturation helper for the complex arithmetic unit.
package cau_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_W    = 32;
  localparam int PROD_W    = 2 * WORD_W;
  localparam int NUM_W     = PROD_W + FRAC_BITS;
  localparam int THR_W     = PROD_W + WORD_W;
  localparam int DIV_STEPS = WORD_W;

  localparam logic [WORD_W-1:0] POS_LIM = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] NEG_LIM = {1'b1, {(WORD_W-1){1'b0}}};

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } mode_t;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    mode_t mode;
    word_t a_real;
    word_t a_imag;
    word_t b_real;
    word_t b_imag;
  } op_t;

  typedef struct packed {
    word_t res_real;
    word_t res_imag;
    logic  overflow;
    logic  div_by_zero;
  } res_t;

  typedef struct packed {
    mode_t              mode;
    logic [WORD_W-1:0]  rr;
    logic [WORD_W-1:0]  ri;
    logic               ovf;
    logic               dz;
    logic               neg_r;
    logic               neg_i;
    logic               sat_r;
    logic               sat_i;
    logic [PROD_W-1:0]  den;
    logic [PROD_W-1:0]  rem_r;
    logic [PROD_W-1:0]  rem_i;
    logic [WORD_W-1:0]  sh_r;
    logic [WORD_W-1:0]  sh_i;
  } dstage_t;

  function automatic logic [WORD_W:0] sat_pack(input logic neg, input logic [PROD_W-1:0] mag);
    logic [PROD_W-1:0] lim;
    logic [WORD_W-1:0] lo;
    logic              ovf;
    lim = {{(PROD_W-WORD_W){1'b0}}, (neg ? NEG_LIM : POS_LIM)};
    ovf = mag > lim;
    lo  = ovf ? lim[WORD_W-1:0] : mag[WORD_W-1:0];
    if (neg) begin
      lo = -lo;
    end
    return {ovf, lo};
  endfunction

endpackage

// File: sv/cau_prep.sv
// Operand products, sums, add/sub/multiply results and divide setup (three stages).
module cau_prep (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            op_valid,
  input  cau_pkg::op_t    op,
  output logic            prep_valid,
  output cau_pkg::dstage_t prep
);

  // stage 1: products
  logic            v1;
  cau_pkg::op_t    op1;
  cau_pkg::prod_t  p_arbr, p_aibi, p_arbi, p_aibr, p_brbr, p_bibi;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1    <= op;
      p_arbr <= cau_pkg::prod_t'(op.a_real) * cau_pkg::prod_t'(op.b_real);
      p_aibi <= cau_pkg::prod_t'(op.a_imag) * cau_pkg::prod_t'(op.b_imag);
      p_arbi <= cau_pkg::prod_t'(op.a_real) * cau_pkg::prod_t'(op.b_imag);
      p_aibr <= cau_pkg::prod_t'(op.a_imag) * cau_pkg::prod_t'(op.b_real);
      p_brbr <= cau_pkg::prod_t'(op.b_real) * cau_pkg::prod_t'(op.b_real);
      p_bibi <= cau_pkg::prod_t'(op.b_imag) * cau_pkg::prod_t'(op.b_imag);
    end
  end

  // stage 2: sums and non-divide results
  logic signed [cau_pkg::PROD_W:0] sr, si;
  logic signed [cau_pkg::WORD_W:0] sa_r, sa_i;
  logic [cau_pkg::PROD_W-1:0]      mag_r_next, mag_i_next, den_next;
  logic [cau_pkg::PROD_W-1:0]      am_r, am_i;
  logic [cau_pkg::WORD_W:0]        pk_r, pk_i;
  logic                            an_r, an_i;

  always_comb begin
    if (op1.mode == cau_pkg::MODE_DIV) begin
      sr = (cau_pkg::PROD_W+1)'(p_arbr) + (cau_pkg::PROD_W+1)'(p_aibi);
      si = (cau_pkg::PROD_W+1)'(p_aibr) - (cau_pkg::PROD_W+1)'(p_arbi);
    end else begin
      sr = (cau_pkg::PROD_W+1)'(p_arbr) - (cau_pkg::PROD_W+1)'(p_aibi);
      si = (cau_pkg::PROD_W+1)'(p_arbi) + (cau_pkg::PROD_W+1)'(p_aibr);
    end
    mag_r_next = sr[cau_pkg::PROD_W] ? cau_pkg::PROD_W'(-sr) : cau_pkg::PROD_W'(sr);
    mag_i_next = si[cau_pkg::PROD_W] ? cau_pkg::PROD_W'(-si) : cau_pkg::PROD_W'(si);
    den_next   = cau_pkg::PROD_W'(p_brbr) + cau_pkg::PROD_W'(p_bibi);

    if (op1.mode == cau_pkg::MODE_SUB) begin
      sa_r = (cau_pkg::WORD_W+1)'(op1.a_real) - (cau_pkg::WORD_W+1)'(op1.b_real);
      sa_i = (cau_pkg::WORD_W+1)'(op1.a_imag) - (cau_pkg::WORD_W+1)'(op1.b_imag);
    end else begin
      sa_r = (cau_pkg::WORD_W+1)'(op1.a_real) + (cau_pkg::WORD_W+1)'(op1.b_real);
      sa_i = (cau_pkg::WORD_W+1)'(op1.a_imag) + (cau_pkg::WORD_W+1)'(op1.b_imag);
    end

    case (op1.mode)
      cau_pkg::MODE_ADD, cau_pkg::MODE_SUB: begin
        an_r = sa_r[cau_pkg::WORD_W];
        an_i = sa_i[cau_pkg::WORD_W];
        am_r = cau_pkg::PROD_W'(an_r ? -sa_r : sa_r);
        am_i = cau_pkg::PROD_W'(an_i ? -sa_i : sa_i);
        am_r = {{(cau_pkg::PROD_W-cau_pkg::WORD_W-1){1'b0}}, am_r[cau_pkg::WORD_W:0]};
        am_i = {{(cau_pkg::PROD_W-cau_pkg::WORD_W-1){1'b0}}, am_i[cau_pkg::WORD_W:0]};
      end
      default: begin
        an_r = sr[cau_pkg::PROD_W];
        an_i = si[cau_pkg::PROD_W];
        am_r = mag_r_next >> cau_pkg::FRAC_BITS;
        am_i = mag_i_next >> cau_pkg::FRAC_BITS;
      end
    endcase
    pk_r = cau_pkg::sat_pack(an_r, am_r);
    pk_i = cau_pkg::sat_pack(an_i, am_i);
  end

  logic                       v2;
  cau_pkg::mode_t             mode2;
  logic [cau_pkg::WORD_W-1:0] rr2, ri2;
  logic                       ovf2, dz2, neg_r2, neg_i2;
  logic [cau_pkg::PROD_W-1:0] mag_r2, mag_i2, den2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode2  <= op1.mode;
      rr2    <= pk_r[cau_pkg::WORD_W-1:0];
      ri2    <= pk_i[cau_pkg::WORD_W-1:0];
      ovf2   <= pk_r[cau_pkg::WORD_W] | pk_i[cau_pkg::WORD_W];
      dz2    <= (op1.mode == cau_pkg::MODE_DIV) && (den_next == '0);
      neg_r2 <= sr[cau_pkg::PROD_W];
      neg_i2 <= si[cau_pkg::PROD_W];
      mag_r2 <= mag_r_next;
      mag_i2 <= mag_i_next;
      den2   <= den_next;
    end
  end

  // stage 3: divide saturation check and remainder setup
  logic [cau_pkg::NUM_W-1:0] num_r, num_i;
  logic [cau_pkg::THR_W-1:0] thr_r, thr_i;

  always_comb begin
    num_r = cau_pkg::NUM_W'(mag_r2) << cau_pkg::FRAC_BITS;
    num_i = cau_pkg::NUM_W'(mag_i2) << cau_pkg::FRAC_BITS;
    thr_r = (cau_pkg::THR_W'(den2) << (cau_pkg::WORD_W-1))
          + (neg_r2 ? cau_pkg::THR_W'(den2) : '0);
    thr_i = (cau_pkg::THR_W'(den2) << (cau_pkg::WORD_W-1))
          + (neg_i2 ? cau_pkg::THR_W'(den2) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prep_valid <= 1'b0;
    end else if (en) begin
      prep_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep.mode  <= mode2;
      prep.rr    <= rr2;
      prep.ri    <= ri2;
      prep.ovf   <= ovf2;
      prep.dz    <= dz2;
      prep.neg_r <= neg_r2;
      prep.neg_i <= neg_i2;
      prep.sat_r <= cau_pkg::THR_W'(num_r) >= thr_r;
      prep.sat_i <= cau_pkg::THR_W'(num_i) >= thr_i;
      prep.den   <= den2;
      prep.rem_r <= cau_pkg::PROD_W'(num_r >> cau_pkg::WORD_W);
      prep.rem_i <= cau_pkg::PROD_W'(num_i >> cau_pkg::WORD_W);
      prep.sh_r  <= num_r[cau_pkg::WORD_W-1:0];
      prep.sh_i  <= num_i[cau_pkg::WORD_W-1:0];
    end
  end

endmodule

// File: sv/cau_div_step.sv
// One restoring-division stage: one quotient bit for each of the two parts.
module cau_div_step (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             step_in_valid,
  input  cau_pkg::dstage_t step_in,
  output logic             step_out_valid,
  output cau_pkg::dstage_t step_out
);

  function automatic logic [cau_pkg::PROD_W:0] trial(input logic [cau_pkg::PROD_W-1:0] rem,
                                                     input logic                       bit_in,
                                                     input logic [cau_pkg::PROD_W-1:0] den);
    logic [cau_pkg::PROD_W:0] t;
    logic                     ge;
    t  = {rem, bit_in};
    ge = t >= {1'b0, den};
    if (ge) begin
      t = t - {1'b0, den};
    end
    return {ge, t[cau_pkg::PROD_W-1:0]};
  endfunction

  logic [cau_pkg::PROD_W:0] tr, ti;
  cau_pkg::dstage_t         nxt;

  always_comb begin
    tr        = trial(step_in.rem_r, step_in.sh_r[cau_pkg::WORD_W-1], step_in.den);
    ti        = trial(step_in.rem_i, step_in.sh_i[cau_pkg::WORD_W-1], step_in.den);
    nxt       = step_in;
    nxt.rem_r = tr[cau_pkg::PROD_W-1:0];
    nxt.rem_i = ti[cau_pkg::PROD_W-1:0];
    nxt.sh_r  = {step_in.sh_r[cau_pkg::WORD_W-2:0], tr[cau_pkg::PROD_W]};
    nxt.sh_i  = {step_in.sh_i[cau_pkg::WORD_W-2:0], ti[cau_pkg::PROD_W]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_out_valid <= 1'b0;
    end else if (en) begin
      step_out_valid <= step_in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      step_out <= nxt;
    end
  end

endmodule

// File: sv/cau_pack.sv
// Final result selection, sign and saturation, and the output register.
module cau_pack (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             fin_valid,
  input  cau_pkg::dstage_t fin,
  output logic             res_valid,
  output cau_pkg::res_t    res
);

  logic [cau_pkg::WORD_W:0] qr, qi;
  cau_pkg::res_t            res_next;

  always_comb begin
    qr = cau_pkg::sat_pack(fin.neg_r, fin.sat_r ? '1 : cau_pkg::PROD_W'(fin.sh_r));
    qi = cau_pkg::sat_pack(fin.neg_i, fin.sat_i ? '1 : cau_pkg::PROD_W'(fin.sh_i));
    if (fin.mode != cau_pkg::MODE_DIV) begin
      res_next.res_real    = fin.rr;
      res_next.res_imag    = fin.ri;
      res_next.overflow    = fin.ovf;
      res_next.div_by_zero = 1'b0;
    end else if (fin.dz) begin
      res_next.res_real    = '0;
      res_next.res_imag    = '0;
      res_next.overflow    = 1'b0;
      res_next.div_by_zero = 1'b1;
    end else begin
      res_next.res_real    = qr[cau_pkg::WORD_W-1:0];
      res_next.res_imag    = qi[cau_pkg::WORD_W-1:0];
      res_next.overflow    = qr[cau_pkg::WORD_W] | qi[cau_pkg::WORD_W];
      res_next.div_by_zero = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

endmodule

// File: sv/complex_arith_unit_core.sv
// Top level of the pipelined complex arithmetic unit.
//
// Requests enter on op (op_valid/op_stall): a mode and two complex operands,
// each part signed Q16.16. Results leave on res (res_valid/res_stall): real
// and imaginary parts, saturated, with overflow and div_by_zero flags.
// Add, subtract, multiply and divide all take the same path, so results
// come out in request order.
// An accepted request reaches res_valid through three setup
// stages (products, sums, divide range check), 32 restoring-division
// stages (one quotient bit per stage), and the output register.
// Throughput is one request per cycle while op_stall is low; the divide pipeline sets the depth.
// Reset clears every valid bit; the pipeline is empty afterwards.
// When res_valid is high and res_stall is high, the whole pipeline holds and
// op_stall is raised in the same cycle; no request is dropped or repeated.
module complex_arith_unit_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          op_valid,
  output logic          op_stall,
  input  cau_pkg::op_t  op,
  output logic          res_valid,
  input  logic          res_stall,
  output cau_pkg::res_t res
);

  logic             en;
  logic             prep_valid;
  cau_pkg::dstage_t prep;
  logic             st_v [0:cau_pkg::DIV_STEPS];
  cau_pkg::dstage_t st_q [0:cau_pkg::DIV_STEPS];

  assign en       = !(res_valid && res_stall);
  assign op_stall = !en;

  cau_prep u_prep (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .op_valid   (op_valid),
    .op         (op),
    .prep_valid (prep_valid),
    .prep       (prep)
  );

  assign st_v[0] = prep_valid;
  assign st_q[0] = prep;

  for (genvar g = 0; g < cau_pkg::DIV_STEPS; g++) begin : g_div
    cau_div_step u_step (
      .clk            (clk),
      .rst            (rst),
      .en             (en),
      .step_in_valid  (st_v[g]),
      .step_in        (st_q[g]),
      .step_out_valid (st_v[g+1]),
      .step_out       (st_q[g+1])
    );
  end

  cau_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .fin_valid (st_v[cau_pkg::DIV_STEPS]),
    .fin       (st_q[cau_pkg::DIV_STEPS]),
    .res_valid (res_valid),
    .res       (res)
  );

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.div_by_zero |-> res.res_real == '0 && res.res_imag == '0 && !res.overflow)
    else $error("div_by_zero result not cleared");

  a_ovf_sat: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.overflow |->
      res.res_real == cau_pkg::POS_LIM || res.res_real == cau_pkg::NEG_LIM ||
      res.res_imag == cau_pkg::POS_LIM || res.res_imag == cau_pkg::NEG_LIM)
    else $error("overflow without a saturated part");

  a_dz_mode: assert property (@(posedge clk) disable iff (rst)
    prep_valid && prep.dz |-> prep.mode == cau_pkg::MODE_DIV)
    else $error("zero divisor flagged outside divide mode");

endmodule

// File: tb/sv/tb.sv
// Testbench for complex_arith_unit_core: queued request driver, result monitor, scoreboard.
module tb;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           op_valid = 1'b0;
  logic           op_stall;
  cau_pkg::op_t   op = '0;
  logic           res_valid;
  logic           res_stall = 1'b0;
  cau_pkg::res_t  res;

  cau_pkg::op_t   pending_ops[$];
  cau_pkg::res_t  expected_res[$];
  int    err_cnt = 0;
  bit    driver_hold = 1'b0;
  bit    calm = 1'b0;
  bit    stim_done = 1'b0;

  complex_arith_unit_core u_dut (
    .clk(clk), .rst(rst), .op_valid(op_valid), .op_stall(op_stall), .op(op),
    .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  always #4 clk = ~clk;

  function automatic logic [32:0] clamp_part(input bit neg, input logic [127:0] mag);
    logic [127:0] lim;
    logic [31:0]  lo;
    bit           ovf;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    ovf = mag > lim;
    lo  = ovf ? lim[31:0] : mag[31:0];
    if (neg) begin
      lo = -lo;
    end
    return {ovf, lo};
  endfunction

  function automatic logic [32:0] scale_signed(input logic signed [127:0] v, input bit div,
                                               input logic [127:0] den);
    bit           neg;
    logic [127:0] mag;
    neg = v < 0;
    mag = neg ? -v : v;
    if (div) begin
      mag = (mag << cau_pkg::FRAC_BITS) / den;
    end else begin
      mag = mag >> cau_pkg::FRAC_BITS;
    end
    return clamp_part(neg, mag);
  endfunction

  function automatic cau_pkg::res_t complex_result(input cau_pkg::op_t r);
    logic signed [127:0] ar, ai, br, bi, pr, pi, den;
    logic [32:0] pr_s, pi_s;
    cau_pkg::res_t o;
    ar = r.a_real; ai = r.a_imag; br = r.b_real; bi = r.b_imag;
    o = '0;
    case (r.mode)
      cau_pkg::MODE_ADD: begin
        pr_s = scale_signed((ar + br) <<< cau_pkg::FRAC_BITS, 1'b0, 0);
        pi_s = scale_signed((ai + bi) <<< cau_pkg::FRAC_BITS, 1'b0, 0);
      end
      cau_pkg::MODE_SUB: begin
        pr_s = scale_signed((ar - br) <<< cau_pkg::FRAC_BITS, 1'b0, 0);
        pi_s = scale_signed((ai - bi) <<< cau_pkg::FRAC_BITS, 1'b0, 0);
      end
      cau_pkg::MODE_MUL: begin
        pr_s = scale_signed(ar * br - ai * bi, 1'b0, 0);
        pi_s = scale_signed(ar * bi + ai * br, 1'b0, 0);
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          pr_s = '0;
          pi_s = '0;
          o.div_by_zero = 1'b1;
        end else begin
          pr = ar * br + ai * bi;
          pi = ai * br - ar * bi;
          pr_s = scale_signed(pr, 1'b1, den);
          pi_s = scale_signed(pi, 1'b1, den);
        end
      end
    endcase
    o.res_real = pr_s[31:0];
    o.res_imag = pi_s[31:0];
    o.overflow = pr_s[32] | pi_s[32];
    return o;
  endfunction

  function automatic cau_pkg::word_t rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'sd0;
      3: return $signed($urandom_range(0, 65535)) - 32'sd32768;
      4, 5: return $signed({{12{1'b0}}, 20'($urandom)}) - 32'sh8_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_request(input cau_pkg::mode_t m, input cau_pkg::word_t a_r,
                             input cau_pkg::word_t a_i, input cau_pkg::word_t b_r,
                             input cau_pkg::word_t b_i);
    cau_pkg::op_t r;
    r.mode = m; r.a_real = a_r; r.a_imag = a_i; r.b_real = b_r; r.b_imag = b_i;
    pending_ops.push_back(r);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else begin
      if (op_valid && !op_stall) begin
        expected_res.push_back(complex_result(op));
      end
      if (op_valid && op_stall) begin
      end else if (!driver_hold && pending_ops.size() > 0 &&
                   (calm || $urandom_range(0, 99) >= 36)) begin
        op       <= pending_ops.pop_front();
        op_valid <= 1'b1;
      end else begin
        op_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cau_pkg::res_t e;
    if (!rst && res_valid && !res_stall) begin
      if (expected_res.size() == 0) begin
        $error("unexpected result real=%h imag=%h", res.res_real, res.res_imag);
        err_cnt++;
      end else begin
        e = expected_res.pop_front();
        if (res.res_real !== e.res_real) begin
          $error("res_real expected %h actual %h", e.res_real, res.res_real);
          err_cnt++;
        end
        if (res.res_imag !== e.res_imag) begin
          $error("res_imag expected %h actual %h", e.res_imag, res.res_imag);
          err_cnt++;
        end
        if (res.overflow !== e.overflow) begin
          $error("overflow expected %b actual %b", e.overflow, res.overflow);
          err_cnt++;
        end
        if (res.div_by_zero !== e.div_by_zero) begin
          $error("div_by_zero expected %b actual %b", e.div_by_zero, res.div_by_zero);
          err_cnt++;
        end
      end
    end
    res_stall <= rst ? 1'b0 : (!calm && $urandom_range(0, 99) < 36);
  end

  initial begin
    cau_pkg::word_t mx, mn;
    cau_pkg::mode_t m;
    mx = 32'h7FFF_FFFF;
    mn = 32'h8000_0000;
    for (int i = 0; i < 4; i++) begin
      m = cau_pkg::mode_t'(i);
      add_request(m, mx, mx, mx, mx);
      add_request(m, mn, mn, mn, mn);
      add_request(m, mx, mn, mn, mx);
      add_request(m, 32'sh1_0000, 32'sh2_0000, 32'sh3_0000, -32'sh1_0000);
    end
    add_request(cau_pkg::MODE_DIV, 32'sh5_0000, 32'sh1_0000, 32'sd0, 32'sd0);
    add_request(cau_pkg::MODE_DIV, mx, mx, 32'sd1, 32'sd0);
    add_request(cau_pkg::MODE_DIV, mn, 32'sd7, 32'sd0, -32'sd1);
    add_request(cau_pkg::MODE_DIV, -32'sd3, 32'sd5, 32'sh2_0000, 32'sd0);
    add_request(cau_pkg::MODE_ADD, -32'sd1, 32'sd1, 32'sd1, -32'sd1);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < 1600; i++) begin
      add_request(cau_pkg::mode_t'($urandom_range(0, 3)), rand_word(), rand_word(),
                  rand_word(), rand_word());
      if (i == 700) begin
        wait (pending_ops.size() == 0);
        @(posedge clk);
        driver_hold = 1'b1;
        wait (expected_res.size() == 0 && !op_valid);
        repeat (40) @(posedge clk);
        driver_hold = 1'b0;
      end
      if (i == 1000) begin
        wait (pending_ops.size() == 0);
        calm = 1'b1;
      end
      if (i == 1300) begin
        wait (pending_ops.size() == 0);
        calm = 1'b0;
      end
    end
    wait (pending_ops.size() == 0);
    @(posedge clk);
    wait (!op_valid && expected_res.size() == 0);
    repeat (60) @(posedge clk);
    if (err_cnt == 0 && expected_res.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// File: sim.f
sv/cau_pkg.sv
sv/cau_prep.sv
sv/cau_div_step.sv
sv/cau_pack.sv
sv/complex_arith_unit_core.sv
tb/sv/tb.sv
